// ----- rtl/key_debounce_autorepeat_top_defines.svh -----
// assertion macros for the key debounce and auto-repeat block
// used by key_debounce_autorepeat_top, expects clk_i and rst_ni in scope
`ifndef KEY_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH

// property checked while out of reset
`define KDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define KDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/kda_pkg.sv -----
// shared types and constants for the key debounce and auto-repeat block
// no dependencies
package kda_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int CNT_W        = 16;
  localparam int MASK_W       = 4;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic [CNT_W-1:0]  DEBOUNCE_RST = 16'd50;
  localparam logic [CNT_W-1:0]  REPEAT_RST   = 16'd250;
  localparam logic [MASK_W-1:0] MASK_RST     = 4'd6;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_REPEAT   = 2'd1;
  localparam logic [1:0] REG_MASK     = 2'd2;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_REPEAT   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_DOWN   = 2'd0,
    EV_UP     = 2'd1,
    EV_REPEAT = 2'd2
  } ev_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_MOD   = 2'd2,
    S_FLUSH = 2'd3
  } state_e;

  // one key's entry in the state memory
  typedef struct packed {
    logic             level;
    phase_e           phase;
    logic [CNT_W-1:0] count;
  } entry_t;

  // memory port controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ----- rtl/kda_keytab.sv -----
// per-key state memory: level, timer phase and countdown, one entry per key
// depends on kda_pkg; entries read as all zero until first written
module kda_keytab #(
  parameter int NUM_KEYS = kda_pkg::NUM_KEYS_DEF,
  parameter int IDX_W    = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kda_pkg::mem_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  kda_pkg::entry_t     wr_data_i,
  output kda_pkg::entry_t     rd_data_o
);

  kda_pkg::entry_t         mem [NUM_KEYS];
  kda_pkg::entry_t         rd_data_q;
  logic [NUM_KEYS-1:0]     written_q;
  logic                    rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // written bits stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_hit_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

// ----- rtl/key_debounce_autorepeat_top.sv -----
// Key debounce and auto-repeat for NUM_KEYS keys. Per-key state lives in a
// single-port-read memory visited by a small sequencer, each entry in a read
// state and then a modify-and-write-back state; a flush state then hands out
// the held-back event. The sequencer waits while the output is stalled and
// more than one event is waiting. Events go out in ascending key order, the
// last one of each transaction flagged.
// Depends on kda_pkg, kda_keytab and key_debounce_autorepeat_top_defines.svh.
`include "key_debounce_autorepeat_top_defines.svh"

module key_debounce_autorepeat_top #(
  parameter int NUM_KEYS = kda_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [1:0]                  key_index_i,
  input  logic                        pressed_level_i,
  // output transactions
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  event_kind_o,
  output logic [1:0]                  event_key_o,
  output logic                        last_event_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kda_pkg::ADDR_W-1:0]  paddr,
  input  logic [kda_pkg::DATA_W-1:0]  pwdata,
  output logic [kda_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  logic [kda_pkg::CNT_W-1:0]  debounce_q, repeat_q;
  logic [kda_pkg::MASK_W-1:0] mask_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kda_pkg::DEBOUNCE_RST;
      repeat_q   <= kda_pkg::REPEAT_RST;
      mask_q     <= kda_pkg::MASK_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        kda_pkg::REG_DEBOUNCE: debounce_q <= pwdata[kda_pkg::CNT_W-1:0];
        kda_pkg::REG_REPEAT:   repeat_q   <= pwdata[kda_pkg::CNT_W-1:0];
        kda_pkg::REG_MASK:     mask_q     <= pwdata[kda_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kda_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_q};
      kda_pkg::REG_REPEAT:   prdata = {16'd0, repeat_q};
      kda_pkg::REG_MASK:     prdata = {28'd0, mask_q};
      default:               prdata = '0;
    endcase
  end

  // sequencer
  kda_pkg::state_e    state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               op_q, op_d;
  logic               lvl_q, lvl_d;
  logic               pend_valid_q, pend_valid_d;
  kda_pkg::ev_e       pend_kind_q, pend_kind_d;
  logic [1:0]         pend_key_q, pend_key_d;
  logic               out_valid_q, out_valid_d;
  kda_pkg::ev_e       out_kind_q, out_kind_d;
  logic [1:0]         out_key_q, out_key_d;
  logic               out_last_q, out_last_d;
  logic               can_push;

  // memory side
  kda_pkg::mem_ctl_t  mem_ctl;
  kda_pkg::entry_t    cur, nxt;
  logic               ev_hit;
  kda_pkg::ev_e       ev_kind;
  logic [5:0]         idx_x;
  logic               key_repeats;

  kda_keytab #(
    .NUM_KEYS (NUM_KEYS),
    .IDX_W    (IDX_W)
  ) u_keytab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (idx_q),
    .wr_addr_i (idx_q),
    .wr_data_i (nxt),
    .rd_data_o (cur)
  );

  assign idx_x       = 6'(idx_q);
  assign key_repeats = (idx_x < 6'd4) && mask_q[idx_x[1:0]];

  // entry update for the key being visited
  always_comb begin
    nxt     = cur;
    ev_hit  = 1'b0;
    ev_kind = kda_pkg::EV_DOWN;
    if (op_q == kda_pkg::OP_EDGE) begin
      // any report cancels the timer
      nxt.phase = kda_pkg::PH_IDLE;
      nxt.count = '0;
      if (lvl_q != cur.level) begin
        nxt.level = lvl_q;
        if (lvl_q) begin
          nxt.phase = kda_pkg::PH_DEBOUNCE;
          nxt.count = debounce_q;
        end else begin
          ev_hit  = 1'b1;
          ev_kind = kda_pkg::EV_UP;
        end
      end
    end else begin
      case (cur.phase)
        kda_pkg::PH_DEBOUNCE: begin
          if (cur.count > 16'd1) begin
            nxt.count = cur.count - 16'd1;
          end else begin
            ev_hit  = 1'b1;
            ev_kind = kda_pkg::EV_DOWN;
            if (key_repeats) begin
              nxt.phase = kda_pkg::PH_REPEAT;
              nxt.count = repeat_q;
            end else begin
              nxt.phase = kda_pkg::PH_IDLE;
              nxt.count = '0;
            end
          end
        end
        kda_pkg::PH_REPEAT: begin
          if (cur.count > 16'd1) begin
            nxt.count = cur.count - 16'd1;
          end else begin
            ev_hit    = 1'b1;
            ev_kind   = kda_pkg::EV_REPEAT;
            nxt.count = repeat_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign can_push = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    op_d          = op_q;
    lvl_d         = lvl_q;
    pend_valid_d  = pend_valid_q;
    pend_kind_d   = pend_kind_q;
    pend_key_d    = pend_key_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_kind_d    = out_kind_q;
    out_key_d     = out_key_q;
    out_last_d    = out_last_q;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    case (state_q)
      kda_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_i;
          lvl_d = pressed_level_i;
          if (op_i == kda_pkg::OP_TICK) begin
            idx_d   = '0;
            state_d = kda_pkg::S_READ;
          end else if (6'(key_index_i) < 6'(NUM_KEYS)) begin
            idx_d   = IDX_W'(key_index_i);
            state_d = kda_pkg::S_READ;
          end
        end
      end
      kda_pkg::S_READ: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = kda_pkg::S_MOD;
      end
      kda_pkg::S_MOD: begin
        // one event is held back so the last one of the transaction can be flagged
        if (!(ev_hit && pend_valid_q && !can_push)) begin
          mem_ctl.wr_en = 1'b1;
          if (ev_hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = pend_kind_q;
              out_key_d   = pend_key_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_kind_d  = ev_kind;
            pend_key_d   = idx_x[1:0];
          end
          if (op_q == kda_pkg::OP_EDGE || idx_q == IDX_W'(NUM_KEYS - 1)) begin
            state_d = kda_pkg::S_FLUSH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = kda_pkg::S_READ;
          end
        end
      end
      kda_pkg::S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = kda_pkg::S_IDLE;
        end else if (can_push) begin
          out_valid_d  = 1'b1;
          out_kind_d   = pend_kind_q;
          out_key_d    = pend_key_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = kda_pkg::S_IDLE;
        end
      end
      default: state_d = kda_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kda_pkg::S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    op_q        <= op_d;
    lvl_q       <= lvl_d;
    pend_kind_q <= pend_kind_d;
    pend_key_q  <= pend_key_d;
    out_kind_q  <= out_kind_d;
    out_key_q   <= out_key_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o   = (state_q != kda_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_key_o  = out_key_q;
  assign last_event_o = out_last_q;

  `KDA_ASSERT(a_idle_no_pend, (state_q == kda_pkg::S_IDLE) |-> !pend_valid_q, "event left pending")
  `KDA_ASSERT(a_idx_range, (state_q != kda_pkg::S_IDLE) |-> (idx_q <= IDX_W'(NUM_KEYS - 1)), "key index out of range")
  `KDA_ASSERT(a_edge_mod, (in_valid_i && !in_stall_o && op_i == kda_pkg::OP_EDGE && 6'(key_index_i) < 6'(NUM_KEYS)) |-> ##2 (state_q == kda_pkg::S_MOD), "edge report lost")
  `KDA_ASSERT_ALWAYS(a_no_rw_same, !(mem_ctl.rd_en && mem_ctl.wr_en), "read and write overlap")

endmodule

// ----- test/testbench.sv -----
// testbench for key_debounce_autorepeat_top: a table of directed transactions, then random ones
// checked against a per-key debounce and repeat predictor kept in the testbench
// depends on kda_pkg and key_debounce_autorepeat_top
`timescale 1ns / 1ps

module testbench;
  import kda_pkg::*;

  localparam int NKEYS       = NUM_KEYS_DEF;
  localparam int SETTLE      = 30;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT  = 3000;
  localparam int NPHASES     = 7;
  localparam int PHASE_ITEMS = 57;
  localparam int NROWS       = 25;

  typedef struct packed {
    ev_e        kind;
    logic [1:0] key;
    logic       last;
  } key_event_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_e;

  typedef struct {
    row_e        rk;
    op_e         op;
    logic [1:0]  key;
    logic        lvl;
    logic        fixed;   // expectation typed into the row
    logic        has_ev;  // fixed row expects one UP event
    logic [15:0] deb;
    logic [15:0] rep;
    logic [3:0]  mask;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                op_i;
  logic [1:0]          key_index_i;
  logic                pressed_level_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          event_kind_o;
  logic [1:0]          event_key_o;
  logic                last_event_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  key_debounce_autorepeat_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .key_index_i     (key_index_i),
    .pressed_level_i (pressed_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .event_key_o     (event_key_o),
    .last_event_o    (last_event_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // predictor state and configuration
  logic        key_lvl   [NKEYS];
  phase_e      key_phase [NKEYS];
  logic [15:0] key_cnt   [NKEYS];
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_repeat;
  logic [3:0]  cfg_mask;

  key_event_t  step_evs [NKEYS];
  int          step_n;
  key_event_t  pending_events [$];
  key_event_t  exp_ev;

  int          mismatch_cnt;
  int          idle_cycles;
  bit          quiet;
  bit          hold_req;

  row_t dir_tab [NROWS] = '{
    // default configuration right after reset
    '{ROW_ITEM, OP_EDGE, 2'd0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd0, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd3, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd2, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    // shortest debounce period and a short repeat period, every key repeats
    '{ROW_CFG,  OP_EDGE, 2'd0, 1'b0, 1'b0, 1'b0, 16'd1, 16'd2, 4'hF},
    '{ROW_ITEM, OP_EDGE, 2'd0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd1, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd2, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd3, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd3, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd1, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd1, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 4'd0},
    // zero periods written while repeat timers are running
    '{ROW_CFG,  OP_EDGE, 2'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 4'h5},
    '{ROW_ITEM, OP_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd1, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd2, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd2, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0},
    // longest periods
    '{ROW_CFG,  OP_EDGE, 2'd0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 4'h0},
    '{ROW_ITEM, OP_EDGE, 2'd3, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_EDGE, 2'd3, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 4'd0},
    '{ROW_ITEM, OP_TICK, 2'd1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 4'd0}
  };

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic log_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t ERROR: %s", $time, msg);
  endtask

  // one edge report or tick applied to the predicted key state
  function automatic void step_keys(input op_e op, input logic [1:0] key, input logic lvl);
    step_n = 0;
    if (op == OP_EDGE) begin
      key_phase[key] = PH_IDLE;
      key_cnt[key]   = '0;
      if (lvl != key_lvl[key]) begin
        key_lvl[key] = lvl;
        if (lvl) begin
          key_phase[key] = PH_DEBOUNCE;
          key_cnt[key]   = cfg_debounce;
        end else begin
          step_evs[step_n] = '{EV_UP, key, 1'b0};
          step_n++;
        end
      end
    end else begin
      for (int k = 0; k < NKEYS; k++) begin
        if (key_phase[k] == PH_IDLE) continue;
        // a countdown of 0 or 1 expires on this tick
        if (key_cnt[k] > 16'd1) begin
          key_cnt[k] = key_cnt[k] - 16'd1;
          continue;
        end
        if (key_phase[k] == PH_DEBOUNCE) begin
          step_evs[step_n] = '{EV_DOWN, 2'(k), 1'b0};
          step_n++;
          if (cfg_mask[k]) begin
            key_phase[k] = PH_REPEAT;
            key_cnt[k]   = cfg_repeat;
          end else begin
            key_phase[k] = PH_IDLE;
            key_cnt[k]   = '0;
          end
        end else begin
          step_evs[step_n] = '{EV_REPEAT, 2'(k), 1'b0};
          step_n++;
          key_cnt[k] = cfg_repeat;
        end
      end
    end
    if (step_n > 0) step_evs[step_n-1].last = 1'b1;
  endfunction

  // offer one input transaction, called at a falling edge, returns at a falling edge
  task automatic send_item(input op_e op, input logic [1:0] key, input logic lvl,
                           input logic fixed, input logic has_ev);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    op_i            = op;
    key_index_i     = key;
    pressed_level_i = lvl;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    // accepted on the last rising edge; results cannot appear before the next one
    step_keys(op, key, lvl);
    if (fixed) begin
      if (has_ev) pending_events.push_back('{EV_UP, key, 1'b1});
    end else begin
      for (int i = 0; i < step_n; i++) pending_events.push_back(step_evs[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    // a tick with no events may still be walking the key entries
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [15:0] rep,
                            input logic [3:0] mask);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, REG_DEBOUNCE, {16'h0, deb}, rd);
    apb_access(1'b1, REG_REPEAT, {16'h0, rep}, rd);
    apb_access(1'b1, REG_MASK, {28'h0, mask}, rd);
    cfg_debounce = deb;
    cfg_repeat   = rep;
    cfg_mask     = mask;
    apb_access(1'b0, REG_DEBOUNCE, 32'h0, rd);
    if (rd !== {16'h0, cfg_debounce})
      log_error($sformatf("debounce_ticks read %h, expected %h", rd, cfg_debounce));
    apb_access(1'b0, REG_REPEAT, 32'h0, rd);
    if (rd !== {16'h0, cfg_repeat})
      log_error($sformatf("repeat_ticks read %h, expected %h", rd, cfg_repeat));
    apb_access(1'b0, REG_MASK, 32'h0, rd);
    if (rd !== {28'h0, cfg_mask})
      log_error($sformatf("repeatable_mask read %h, expected %h", rd, cfg_mask));
  endtask

  task automatic send_random();
    op_e op;
    op = ($urandom_range(0, 99) < 70) ? OP_TICK : OP_EDGE;
    send_item(op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
  endtask

  // output checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          log_error($sformatf("unexpected event kind %0d key %0d last %0d",
                              event_kind_o, event_key_o, last_event_o));
        end else begin
          exp_ev = pending_events.pop_front();
          if (event_kind_o !== exp_ev.kind || event_key_o !== exp_ev.key ||
              last_event_o !== exp_ev.last)
            log_error($sformatf("event kind/key/last %0d/%0d/%0d, expected %0d/%0d/%0d",
                                event_kind_o, event_key_o, last_event_o,
                                exp_ev.kind, exp_ev.key, exp_ev.last));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stall per event, plus one long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 3);
      out_stall_i = (n != 0);
      repeat (n) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !hold_req);
    end
  end

  initial begin
    logic [15:0] deb;
    logic [15:0] rep;
    in_valid_i      = 1'b0;
    op_i            = OP_EDGE;
    key_index_i     = '0;
    pressed_level_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatch_cnt    = 0;
    idle_cycles     = 0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    cfg_debounce    = DEBOUNCE_RST;
    cfg_repeat      = REPEAT_RST;
    cfg_mask        = MASK_RST;
    for (int k = 0; k < NKEYS; k++) begin
      key_lvl[k]   = 1'b0;
      key_phase[k] = PH_IDLE;
      key_cnt[k]   = '0;
    end
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].rk == ROW_CFG)
        set_config(dir_tab[i].deb, dir_tab[i].rep, dir_tab[i].mask);
      else
        send_item(dir_tab[i].op, dir_tab[i].key, dir_tab[i].lvl,
                  dir_tab[i].fixed, dir_tab[i].has_ev);
    end

    for (int p = 0; p < NPHASES; p++) begin
      if (p == 0) begin
        set_config(16'hFFFF, 16'hFFFF, 4'hF);
      end else if (p == 1) begin
        set_config(16'd1, 16'd1, 4'h0);
      end else if (p == 2) begin
        // every key repeating each tick while the receiver holds off
        set_config(16'd1, 16'd1, 4'hF);
        for (int k = 0; k < NKEYS; k++) send_item(OP_EDGE, 2'(k), 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < NKEYS; k++) send_item(OP_EDGE, 2'(k), 1'b1, 1'b0, 1'b0);
        quiet    = 1'b1;
        hold_req = 1'b1;
        repeat (20) send_item(OP_TICK, 2'd0, 1'b0, 1'b0, 1'b0);
      end else begin
        deb = 16'($urandom_range(1, 6));
        rep = 16'($urandom_range(1, 8));
        set_config(deb, rep, 4'($urandom_range(0, 15)));
      end
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p == 3) wait_drained();
        send_random();
      end
    end

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- key_debounce_autorepeat_top.f -----
+incdir+rtl
rtl/kda_pkg.sv
rtl/kda_keytab.sv
rtl/key_debounce_autorepeat_top.sv
test/testbench.sv
